FILE: hw/rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared constants, register codes, link types and the case folding helper.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int NUM_CELLS   = MAX_PATTERN + 1;
    localparam int PAT_WORDS   = 4;
    localparam int PAT_BYTES   = 8 * PAT_WORDS;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_LEN_W   = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] QUERY_CHAR = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH  = 3'd0,
        REG_PATTERN_BYTES_0 = 3'd1,
        REG_PATTERN_BYTES_1 = 3'd2,
        REG_PATTERN_BYTES_2 = 3'd3,
        REG_PATTERN_BYTES_3 = 3'd4
    } wgm_reg_t;

    typedef struct packed {
        logic start;
        logic empty;
        logic load;
    } wgm_ctl_t;

    typedef struct packed {
        logic base;
        logic adv;
        logic star;
        logic nxt;
    } wgm_link_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]})
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/wgm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher position cell
// Holds one bit of the live position set and updates it from its left neighbor.
// ----------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wgm_ctl_t   ctl,
    input  logic [7:0] text_up,
    input  logic [7:0] pat_byte,
    input  logic       active,
    input  wgm_link_t  left,
    output wgm_link_t  right,
    output logic       live
);

    logic live_reg;
    logic live_next;
    logic is_star;
    logic is_adv;
    logic base;
    logic pre;

    always_comb
    begin
        is_star   = active && (pat_byte == STAR_CHAR);
        is_adv    = active && !is_star &&
                    ((pat_byte == QUERY_CHAR) || (upcase(pat_byte) == text_up));
        base      = ctl.start ? (left.base & left.star) : live_reg;
        pre       = (left.base & left.adv) | (base & is_star);
        live_next = ctl.empty ? base : (pre | (left.nxt & left.star));
    end

    assign right = '{base: base, adv: is_adv, star: is_star, nxt: live_next};
    assign live  = live_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            live_reg <= live_next;
        end
    end

endmodule

FILE: hw/rtl/wildcard_glob_matcher_core.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher core
// Case-insensitive '?' and '*' pattern match over a byte stream.
// ----------------------------------------------------------------------------
// The pattern and its length are written through the cfg channel (index 0 is
// the length, indexes 1 to 4 hold pattern bytes 0 to 31, lowest byte first).
// Text bytes arrive on the in channel, one beat per byte; a beat with last
// set closes the text, and a beat with is_empty set carries no byte.
// For every beat with last set, one beat with matched leaves on the out
// channel.
// The text is tracked as a set of live pattern positions held in a row of
// cells, one per position; each beat updates the whole row at once, so the
// block takes one beat per cycle while the out channel is not stalled. The
// result is registered: it appears in the cycle after the last beat is taken.
// When the receiver stalls, the result is held and in_ready drops until it is
// taken; non-last beats are then held off too.
// Reset clears the pattern, its length and the position set, and the next
// beat starts a new text.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_core
    import wgm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            text_char,
    input  logic                  is_empty,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  matched
);

    logic [CFG_LEN_W-1:0]  len_reg;
    logic [CFG_LEN_W-1:0]  len_next;
    logic [CFG_DATA_W-1:0] word_reg  [PAT_WORDS];
    logic [CFG_DATA_W-1:0] word_next [PAT_WORDS];
    logic                  start_reg;
    logic                  start_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  matched_reg;
    logic                  matched_next;

    logic                  cfg_fire;
    logic                  in_fire;
    logic [LEN_W-1:0]      len_eff;
    logic [7:0]            text_up;
    wgm_ctl_t              ctl;
    wgm_link_t             link [NUM_CELLS+1];
    logic [NUM_CELLS-1:0]  live;
    logic [NUM_CELLS-1:0]  end_sel;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    always_comb
    begin
        len_next  = len_reg;
        word_next = word_reg;
        if (cfg_fire)
        begin
            case (wgm_reg_t'(cfg_index))
                REG_PATTERN_LENGTH:  len_next     = cfg_data[CFG_LEN_W-1:0];
                REG_PATTERN_BYTES_0: word_next[0] = cfg_data;
                REG_PATTERN_BYTES_1: word_next[1] = cfg_data;
                REG_PATTERN_BYTES_2: word_next[2] = cfg_data;
                REG_PATTERN_BYTES_3: word_next[3] = cfg_data;
                default:             len_next     = len_reg;
            endcase
        end
    end

    always_comb
    begin
        if (int'(len_reg) > MAX_PATTERN)
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = LEN_W'(len_reg);
        end
    end

    assign text_up = upcase(text_char);
    assign ctl     = '{start: start_reg, empty: is_empty, load: in_fire};
    assign link[0] = '{base: 1'b1, adv: 1'b0, star: 1'b1, nxt: 1'b0};

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic [7:0] pat_byte;
        logic       active;

        if (i < PAT_BYTES)
        begin : g_byte
            assign pat_byte = word_reg[i / 8][(i % 8) * 8 +: 8];
        end
        else
        begin : g_zero
            assign pat_byte = 8'h00;
        end

        assign active     = len_eff > LEN_W'(i);
        assign end_sel[i] = len_eff == LEN_W'(i);

        wgm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .text_up  (text_up),
            .pat_byte (pat_byte),
            .active   (active),
            .left     (link[i]),
            .right    (link[i+1]),
            .live     (live[i])
        );
    end

    always_comb
    begin
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        if (in_fire)
        begin
            start_next = last;
            if (last)
            begin
                out_valid_next = 1'b1;
                matched_next   = |(live & end_sel);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            word_reg      <= '{default: '0};
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            word_reg      <= word_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

endmodule

FILE: hw/rtl/wgm_checker.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher port checker
// Watches the top level ports for result ordering and back pressure.
// ----------------------------------------------------------------------------
module wgm_checker
    import wgm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic last,
    input logic out_valid,
    input logic out_ready,
    input logic matched
);

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> out_valid)
        else $error("Last beat did not produce a result beat.");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last && (!out_valid || out_ready)) |=> !out_valid)
        else $error("Result beat appeared without a last beat.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("Input taken while a result is stalled.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(matched)))
        else $error("Stalled result beat changed or vanished.");

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .matched   (matched)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Loads patterns through the register channel and streams texts, one byte per
// beat, with random gaps on both sides. A model of the live pattern position
// set predicts the verdict of every text, and each verdict beat that leaves
// the block is compared with the oldest prediction still due.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wgm_pkg::*;

    class glob_match_predictor;
        logic [CFG_LEN_W-1:0]  pat_len = '0;
        logic [CFG_DATA_W-1:0] pat_words [PAT_WORDS] = '{default: '0};
        logic [NUM_CELLS-1:0]  live_set = '0;
        bit                    fresh_text = 1'b1;
        bit                    verdicts_due [$];
        int                    mismatches = 0;

        function void write_reg(wgm_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_LENGTH:  pat_len = data[CFG_LEN_W-1:0];
                REG_PATTERN_BYTES_0: pat_words[0] = data;
                REG_PATTERN_BYTES_1: pat_words[1] = data;
                REG_PATTERN_BYTES_2: pat_words[2] = data;
                REG_PATTERN_BYTES_3: pat_words[3] = data;
                default: ;
            endcase
        endfunction

        function int span();
            return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        endfunction

        function logic [7:0] pattern_char(int i);
            if (i >= PAT_BYTES)
            begin
                return 8'h00;
            end
            return pat_words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function logic [7:0] fold_case(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
        endfunction

        function logic [NUM_CELLS-1:0] spread_stars(logic [NUM_CELLS-1:0] s, int n);
            for (int i = 0; i < n; i++)
            begin
                if (s[i] && pattern_char(i) == STAR_CHAR)
                begin
                    s[i + 1] = 1'b1;
                end
            end
            return s;
        endfunction

        function void note_text_beat(logic [7:0] c, logic e, logic l);
            int                   n;
            logic [NUM_CELLS-1:0] nxt;
            logic [7:0]           p;
            n = span();
            if (fresh_text)
            begin
                live_set = '0;
                live_set[0] = 1'b1;
                live_set = spread_stars(live_set, n);
                fresh_text = 1'b0;
            end
            if (!e)
            begin
                nxt = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (live_set[i])
                    begin
                        p = pattern_char(i);
                        if (p == STAR_CHAR)
                        begin
                            nxt[i] = 1'b1;
                        end
                        else if (p == QUERY_CHAR || fold_case(p) == fold_case(c))
                        begin
                            nxt[i + 1] = 1'b1;
                        end
                    end
                end
                live_set = spread_stars(nxt, n);
            end
            if (l)
            begin
                verdicts_due.push_back(live_set[n]);
                fresh_text = 1'b1;
            end
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("verdict beat matched=%0b with none due at %0t", got, $realtime);
                end
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("verdict mismatch at %0t: expected matched=%0b, got %0b",
                             $realtime, want, got);
                end
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    wgm_reg_t              cfg_index = REG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            text_char = 8'h00;
    logic                  is_empty = 1'b0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic                  matched;

    glob_match_predictor   verdict_model;
    bit                    tx_idle_on = 1'b0;
    bit                    rx_idle_on = 1'b0;
    int                    beats_sent = 0;
    int                    cur_len = 0;
    logic [CFG_DATA_W-1:0] cur_words [PAT_WORDS];
    logic [7:0]            text_buf [$];

    wildcard_glob_matcher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_char (text_char),
        .is_empty  (is_empty),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                verdict_model.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                verdict_model.note_text_beat(text_char, is_empty, last);
            end
            if (out_valid && out_ready)
            begin
                verdict_model.check_verdict(matched);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_beat(input logic [7:0] c, input logic e, input logic l);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_char <= c;
        is_empty  <= e;
        last      <= l;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_word(input string s);
        if (s.len() == 0)
        begin
            push_beat(8'h00, 1'b1, 1'b1);
        end
        for (int k = 0; k < s.len(); k++)
        begin
            push_beat(s[k], 1'b0, k == s.len() - 1);
        end
    endtask

    task automatic send_text();
        int n;
        n = text_buf.size();
        if (n == 0)
        begin
            push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            beats_sent++;
        end
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            push_beat(text_buf[k], 1'b0, k == n - 1);
            beats_sent++;
        end
    endtask

    // Holds the sender back until every verdict has come and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_model.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_pattern();
        cfg_valid <= 1'b1;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= CFG_DATA_W'(cur_len);
        do @(posedge clk); while (!cfg_ready);
        for (int w = 0; w < PAT_WORDS; w++)
        begin
            cfg_index <= wgm_reg_t'(int'(REG_PATTERN_BYTES_0) + w);
            cfg_data  <= cur_words[w];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void pattern_from(input string s);
        cur_len = s.len();
        foreach (cur_words[w])
        begin
            cur_words[w] = '0;
        end
        for (int k = 0; k < s.len(); k++)
        begin
            cur_words[k / 8][(k % 8) * 8 +: 8] = s[k];
        end
    endfunction

    function automatic logic [7:0] pick_pattern_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = STAR_CHAR;
            2, 3:    c = QUERY_CHAR;
            4:       c = "a";
            5:       c = "B";
            6:       c = "c";
            7:       c = "z";
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = "A";
            1:       c = "b";
            2:       c = "C";
            3:       c = "z";
            4:       c = STAR_CHAR;
            5:       c = QUERY_CHAR;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic int span_of_pattern();
        return (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
    endfunction

    function automatic void new_random_pattern();
        int r;
        int n;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            cur_len = 0;
        end
        else if (r == 1)
        begin
            cur_len = MAX_PATTERN;
        end
        else if (r == 2)
        begin
            cur_len = $urandom_range(MAX_PATTERN + 1, 63);
        end
        else if (r <= 4)
        begin
            cur_len = $urandom_range(9, MAX_PATTERN - 1);
        end
        else
        begin
            cur_len = $urandom_range(1, 8);
        end
        n = span_of_pattern();
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            cur_words[k / 8][(k % 8) * 8 +: 8] =
                (k < n) ? pick_pattern_char() : 8'($urandom_range(0, 255));
        end
    endfunction

    // Mostly texts built to fit the pattern, some of them spoiled, a few pure noise.
    function automatic void build_text();
        int         n;
        int         r;
        int         j;
        logic [7:0] p;
        text_buf.delete();
        r = $urandom_range(0, 19);
        if (r < 3)
        begin
            repeat ($urandom_range(0, 8)) text_buf.push_back(pick_text_char());
            return;
        end
        n = span_of_pattern();
        for (int k = 0; k < n; k++)
        begin
            p = cur_words[k / 8][(k % 8) * 8 +: 8];
            if (p == STAR_CHAR)
            begin
                repeat ($urandom_range(0, 3)) text_buf.push_back(pick_text_char());
            end
            else if (p == QUERY_CHAR)
            begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if ((p >= "A" && p <= "Z") || (p >= "a" && p <= "z"))
            begin
                text_buf.push_back(p ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
            end
            else
            begin
                text_buf.push_back(p);
            end
        end
        if (r < 10)
        begin
            if (text_buf.size() == 0)
            begin
                text_buf.push_back(pick_text_char());
            end
            else
            begin
                j = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0:       text_buf[j] = pick_text_char();
                    1:       text_buf.delete(j);
                    default: text_buf.insert(j, pick_text_char());
                endcase
            end
        end
    endfunction

    initial
    begin
        bit pressure_done;
        bit quiet;
        verdict_model = new;
        pressure_done = 1'b0;
        foreach (cur_words[w])
        begin
            cur_words[w] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_word("");
        push_beat(8'hFF, 1'b0, 1'b1);
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'h00, 1'b1, 1'b1);

        settle();
        pattern_from("a?*");
        cur_len = 4;
        load_pattern();
        push_beat("A", 1'b0, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b0);
        push_beat("x", 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1);
        push_beat("a", 1'b0, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'h80, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1);
        send_word("");

        settle();
        pattern_from("**");
        load_pattern();
        send_word("");
        send_word("*");

        settle();
        pattern_from("Zq");
        load_pattern();
        send_word("zQ");
        send_word("z?");

        settle();
        cur_len = 63;
        foreach (cur_words[w])
        begin
            cur_words[w] = '1;
        end
        load_pattern();
        push_beat(8'hFF, 1'b0, 1'b1);

        settle();
        cur_len = 1;
        load_pattern();
        push_beat(8'hFF, 1'b0, 1'b1);

        settle();
        pattern_from("");
        cur_len = 1;
        load_pattern();
        push_beat(8'h00, 1'b0, 1'b1);

        settle();
        cur_len = 63;
        foreach (cur_words[w])
        begin
            cur_words[w] = {8{STAR_CHAR}};
        end
        load_pattern();
        send_word("Zz");

        // The live set survives a pattern change in the middle of a text.
        settle();
        pattern_from("ab");
        load_pattern();
        push_beat("a", 1'b0, 1'b0);
        settle();
        pattern_from("a*");
        load_pattern();
        push_beat("Z", 1'b0, 1'b1);

        beats_sent = 0;
        while (beats_sent < 1250)
        begin
            settle();
            new_random_pattern();
            load_pattern();
            quiet = (beats_sent >= 1050);
            tx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
            rx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(6, 15))
            begin
                build_text();
                send_text();
                if (!pressure_done && beats_sent >= 600)
                begin
                    settle();
                    pressure_done = 1'b1;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_model.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (verdict_model.mismatches == 0 && verdict_model.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_cell.sv
hw/rtl/wildcard_glob_matcher_core.sv
hw/rtl/wgm_checker.sv
dv/testbench.sv
